// ===== sv/pidc_pkg.sv =====
// Shared widths, register indexes and constants for the PID controller.
package pidc_pkg;

  localparam int DW        = 16;  // measurement, setpoint, gains, limits, drive
  localparam int ERR_W     = 17;  // exact difference of two 16-bit values
  localparam int MS_W      = 10;  // effective elapsed time, 0..1000
  localparam int GE_W      = 33;  // 16 x 17 signed product
  localparam int MA_W      = 34;  // multiplier operand A
  localparam int MB_W      = 17;  // multiplier operand B
  localparam int MP_W      = MA_W + MB_W;
  localparam int MAG_W     = 42;  // |gain * err * ms| fits here
  localparam int DIV_SHIFT = 5;   // x256/1000 == x32/125
  localparam int DIV_W     = MAG_W + DIV_SHIFT;
  localparam int DIVISOR   = 125;
  localparam int REM_W     = 7;
  localparam int DCH_W     = 16;              // dividend chunk per reciprocal step
  localparam int DCH_N     = 3;
  localparam int DWORK_W   = DCH_W * DCH_N;   // holds the DIV_W dividend
  localparam int DV_W      = REM_W + DCH_W;   // partial dividend, < 125 * 2^16
  localparam int RECIP_W   = 24;
  localparam int RECIP_SH  = 30;
  localparam int DP_W      = DV_W + RECIP_W;
  localparam int DIV_CNT_W = 3;
  localparam int DIV_STEPS = 2 * DCH_N;       // multiply, then fold back
  localparam int INT_W     = 32;  // Q16.16 integral
  localparam int FRAC_W    = 16;
  localparam int ACC_W     = 48;
  localparam int SUM_W     = 44;
  localparam int FLR_W     = SUM_W - FRAC_W;
  localparam int CFG_IDX_W = 3;

  localparam logic [DW-1:0] MS_LIMIT = 16'd1000;

  // ceil(2^30 / 125); exact floor for any partial dividend below 2^23
  localparam logic [RECIP_W-1:0] RECIP_125 = 24'd8589935;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PROP_GAIN  = 3'd0;
  localparam cfg_idx_t REG_INTEG_GAIN = 3'd1;
  localparam cfg_idx_t REG_DERIV_GAIN = 3'd2;
  localparam cfg_idx_t REG_OUT_MIN    = 3'd3;
  localparam cfg_idx_t REG_OUT_MAX    = 3'd4;

  localparam logic signed [DW-1:0] OUT_MIN_RST = 16'sh8000;
  localparam logic signed [DW-1:0] OUT_MAX_RST = 16'sh7fff;

endpackage

// ===== sv/pidc_mul.sv =====
// Shared signed multiplier with a registered product.
module pidc_mul import pidc_pkg::*; (
  input  logic                   clk,
  input  logic signed [MA_W-1:0] mul_a,
  input  logic signed [MB_W-1:0] mul_b,
  output logic signed [MP_W-1:0] mul_p
);

  logic signed [MP_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  assign mul_p = prod_r;

endmodule

// ===== sv/pidc_div.sv =====
// Divider by the constant 125: reciprocal multiply on 16-bit chunks, a multiply step and a fold-back step per chunk.
module pidc_div import pidc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             div_start,
  input  logic [DIV_W-1:0] div_dividend,
  output logic             div_busy,
  output logic [DIV_W-1:0] div_quot
);

  logic [DWORK_W-1:0]   work_r;
  logic [REM_W-1:0]     rem_r;
  logic [DV_W-1:0]      part_r;
  logic [DP_W-1:0]      prod_r;
  logic [DIV_CNT_W-1:0] cnt_r;
  logic                 busy_r;
  logic [DV_W-1:0]      part;
  logic [DCH_W-1:0]     qchunk;
  logic [DV_W-1:0]      back;

  // remainder so far on top of the next chunk
  assign part   = {rem_r, work_r[DWORK_W-1 -: DCH_W]};
  assign qchunk = prod_r[RECIP_SH +: DCH_W];
  assign back   = DV_W'(qchunk) * DV_W'(DIVISOR);

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (div_start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  // even step: 23 x 24 product with the reciprocal
  // odd step: quotient chunk shifts in behind the dividend, remainder folds back
  always_ff @(posedge clk) begin
    if (div_start) begin
      work_r <= {{(DWORK_W-DIV_W){1'b0}}, div_dividend};
      rem_r  <= '0;
    end else if (busy_r) begin
      if (!cnt_r[0]) begin
        part_r <= part;
        prod_r <= DP_W'(part) * DP_W'(RECIP_125);
      end else begin
        work_r <= {work_r[DWORK_W-DCH_W-1:0], qchunk};
        rem_r  <= REM_W'(part_r - back);
      end
    end
  end

  assign div_busy = busy_r;
  assign div_quot = work_r[DIV_W-1:0];

endmodule

// ===== sv/pid_controller_clamped.sv =====
// Top level of the fixed-point PID controller with clamped integral and output.
//
//  channel | handshake           | payload
//  --------+---------------------+------------------------------------------
//  cfg     | cfg_we              | cfg_index, cfg_wdata (16b)
//  in      | in_valid / in_stall | in_measurement, in_setpoint, in_elapsed_ms
//  out     | out_valid/out_stall | out_drive
//
// One item at a time. An item runs from its transfer through the chained
// multiplies and the reciprocal divide by 125 for the integral term to
// out_valid; the sequencer goes back to idle after the result transfer and
// only then takes the next item.
// Reset (rst_n low, synchronous) clears gains, restores the limits, zeroes
// the integral and previous measurement, and arms the first-step flag.
// in_stall is high from the input transfer until the result is taken; a
// stalled out_drive holds in its register.
module pid_controller_clamped import pidc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [DW-1:0]        cfg_wdata,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [DW-1:0] in_measurement,
  input  logic signed [DW-1:0] in_setpoint,
  input  logic [DW-1:0]        in_elapsed_ms,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [DW-1:0] out_drive
);

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_M1    = 4'd1;   // integ_gain * err
  localparam logic [3:0] ST_M2    = 4'd2;   // (.. ) * ms
  localparam logic [3:0] ST_M3    = 4'd3;   // start divide, prop_gain * err
  localparam logic [3:0] ST_M4    = 4'd4;   // deriv_gain * dmeas
  localparam logic [3:0] ST_M5    = 4'd5;
  localparam logic [3:0] ST_DIVW  = 4'd6;
  localparam logic [3:0] ST_ACCA  = 4'd7;
  localparam logic [3:0] ST_ACCC  = 4'd8;
  localparam logic [3:0] ST_SUM1  = 4'd9;
  localparam logic [3:0] ST_SUM2  = 4'd10;
  localparam logic [3:0] ST_OUTC  = 4'd11;
  localparam logic [3:0] ST_OUT   = 4'd12;

  logic [3:0] state_r, state_nxt;

  // configuration
  logic signed [DW-1:0] prop_gain_r, integ_gain_r, deriv_gain_r;
  logic signed [DW-1:0] out_min_r, out_max_r;

  // controller state
  logic signed [INT_W-1:0] integral_r;
  logic signed [DW-1:0]    prev_meas_r;
  logic                    first_r;

  // per-item working registers
  logic signed [ERR_W-1:0] err_r, dmeas_r;
  logic [MS_W-1:0]         ms_r;
  logic                    neg_r;
  logic signed [GE_W-1:0]  pterm_r, dterm_r;
  logic signed [ACC_W-1:0] accsum_r;
  logic signed [SUM_W-1:0] sum_r;
  logic signed [DW-1:0]    drive_r;

  logic in_xfer;
  assign in_stall = (state_r != ST_IDLE);
  assign in_xfer  = in_valid && !in_stall;

  // shared multiplier operand select
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic signed [MP_W-1:0] mul_p;

  always_comb begin
    case (state_r)
      ST_M1: begin
        mul_a = {{(MA_W-DW){integ_gain_r[DW-1]}}, integ_gain_r};
        mul_b = err_r;
      end
      ST_M2: begin
        mul_a = {mul_p[GE_W-1], mul_p[GE_W-1:0]};
        mul_b = {{(MB_W-MS_W){1'b0}}, ms_r};
      end
      ST_M3: begin
        mul_a = {{(MA_W-DW){prop_gain_r[DW-1]}}, prop_gain_r};
        mul_b = err_r;
      end
      ST_M4: begin
        mul_a = {{(MA_W-DW){deriv_gain_r[DW-1]}}, deriv_gain_r};
        mul_b = dmeas_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  pidc_mul u_mul (
    .clk   (clk),
    .mul_a (mul_a),
    .mul_b (mul_b),
    .mul_p (mul_p)
  );

  // |integ_gain*err*ms| * 32, divided by 125 -> Q16.16 increment magnitude
  logic [MP_W-1:0]  prod_mag;
  logic             div_start;
  logic [DIV_W-1:0] div_dividend;
  logic             div_busy;
  logic [DIV_W-1:0] div_quot;

  assign prod_mag     = mul_p[MP_W-1] ? (-mul_p) : mul_p;
  assign div_start    = (state_r == ST_M3);
  assign div_dividend = {prod_mag[MAG_W-1:0], {DIV_SHIFT{1'b0}}};

  pidc_div u_div (
    .clk          (clk),
    .rst_n        (rst_n),
    .div_start    (div_start),
    .div_dividend (div_dividend),
    .div_busy     (div_busy),
    .div_quot     (div_quot)
  );

  // limits in Q16.16 and in integer form
  logic signed [ACC_W-1:0] lo_q, hi_q, integ_ext, acc_clamped;
  logic [ACC_W-1:0]        quot_ext;
  logic signed [FLR_W-1:0] flr, lo_i, hi_i, drv_clamped;

  assign lo_q      = {{(ACC_W-DW-FRAC_W){out_min_r[DW-1]}}, out_min_r, {FRAC_W{1'b0}}};
  assign hi_q      = {{(ACC_W-DW-FRAC_W){out_max_r[DW-1]}}, out_max_r, {FRAC_W{1'b0}}};
  assign integ_ext = {{(ACC_W-INT_W){integral_r[INT_W-1]}}, integral_r};
  assign quot_ext  = {{(ACC_W-DIV_W){1'b0}}, div_quot};

  // above max wins, then below min
  assign acc_clamped = (accsum_r > hi_q) ? hi_q :
                       (accsum_r < lo_q) ? lo_q : accsum_r;

  // floor toward minus infinity is an arithmetic shift
  assign flr  = sum_r[SUM_W-1:FRAC_W];
  assign lo_i = {{(FLR_W-DW){out_min_r[DW-1]}}, out_min_r};
  assign hi_i = {{(FLR_W-DW){out_max_r[DW-1]}}, out_max_r};
  assign drv_clamped = (flr > hi_i) ? hi_i :
                       (flr < lo_i) ? lo_i : flr;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_xfer) state_nxt = ST_M1;
      ST_M1:   state_nxt = ST_M2;
      ST_M2:   state_nxt = ST_M3;
      ST_M3:   state_nxt = ST_M4;
      ST_M4:   state_nxt = ST_M5;
      ST_M5:   state_nxt = ST_DIVW;
      ST_DIVW: if (!div_busy) state_nxt = ST_ACCA;
      ST_ACCA: state_nxt = ST_ACCC;
      ST_ACCC: state_nxt = ST_SUM1;
      ST_SUM1: state_nxt = ST_SUM2;
      ST_SUM2: state_nxt = ST_OUTC;
      ST_OUTC: state_nxt = ST_OUT;
      ST_OUT:  if (!out_stall) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // configuration writes; indexes past the list are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r  <= '0;
      integ_gain_r <= '0;
      deriv_gain_r <= '0;
      out_min_r    <= OUT_MIN_RST;
      out_max_r    <= OUT_MAX_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PROP_GAIN:  prop_gain_r  <= cfg_wdata;
        REG_INTEG_GAIN: integ_gain_r <= cfg_wdata;
        REG_DERIV_GAIN: deriv_gain_r <= cfg_wdata;
        REG_OUT_MIN:    out_min_r    <= cfg_wdata;
        REG_OUT_MAX:    out_max_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // controller state: measurement history and integral
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r  <= '0;
      prev_meas_r <= '0;
      first_r     <= 1'b1;
    end else begin
      if (in_xfer) begin
        prev_meas_r <= in_measurement;
        first_r     <= 1'b0;
      end
      if (state_r == ST_ACCC) begin
        integral_r <= acc_clamped[INT_W-1:0];
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      err_r   <= {in_setpoint[DW-1], in_setpoint} - {in_measurement[DW-1], in_measurement};
      dmeas_r <= first_r ? '0 :
                 {in_measurement[DW-1], in_measurement} - {prev_meas_r[DW-1], prev_meas_r};
      ms_r    <= (in_elapsed_ms > MS_LIMIT) ? '0 : in_elapsed_ms[MS_W-1:0];
    end
    case (state_r)
      ST_M3:   neg_r    <= mul_p[MP_W-1];
      ST_M4:   pterm_r  <= mul_p[GE_W-1:0];
      ST_M5:   dterm_r  <= mul_p[GE_W-1:0];
      ST_ACCA: accsum_r <= neg_r ? (integ_ext - quot_ext) : (integ_ext + quot_ext);
      ST_SUM1: sum_r    <= {{(SUM_W-GE_W-8){pterm_r[GE_W-1]}}, pterm_r, 8'b0}
                           + integ_ext[SUM_W-1:0];
      ST_SUM2: sum_r    <= sum_r - {{(SUM_W-GE_W-8){dterm_r[GE_W-1]}}, dterm_r, 8'b0};
      ST_OUTC: drive_r  <= drv_clamped[DW-1:0];
      default: ;
    endcase
  end

  assign out_valid = (state_r == ST_OUT);
  assign out_drive = drive_r;

`ifndef SYNTHESIS
  // a pending result keeps the input closed
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

  // divider only runs between its start and the wait state
  a_div_window: assert property (@(posedge clk) disable iff (!rst_n)
    div_busy |-> (state_r == ST_M4 || state_r == ST_M5 || state_r == ST_DIVW))
    else $error("divider busy outside its window");

  // an input transfer starts the sequence and drops the first-step flag
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == ST_M1 && !first_r))
    else $error("sequence did not start after input transfer");

  // with ordered limits the clamped integral lies inside them
  a_integ_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SUM1 && out_min_r <= out_max_r) |->
      (integ_ext >= lo_q && integ_ext <= hi_q))
    else $error("integral outside limits");
`endif

endmodule
